// ===== hdl/assert_macros.svh =====
// Assertion macros for the UTF-16 to UTF-8 transcoder; clocked on i_clk, off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true.
`define U2U_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define U2U_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define U2U_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/u2u_pkg.sv =====
// Package: shared types and constants of the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps
package u2u_pkg;

    localparam int C_MAX_BYTES = 6;
    localparam int C_CNT_W     = $clog2(C_MAX_BYTES + 1);
    localparam int C_IDX_W     = $clog2(C_MAX_BYTES);

    // Upper six bits that tag surrogates
    localparam logic [5:0] C_HIGH_TAG = 6'b110110;
    localparam logic [5:0] C_LOW_TAG  = 6'b110111;

    // UTF-8 lead and continuation markers
    localparam logic [7:0] C_LEAD2 = 8'hC0;
    localparam logic [7:0] C_LEAD3 = 8'hE0;
    localparam logic [7:0] C_LEAD4 = 8'hF0;
    localparam logic [7:0] C_CONT  = 8'h80;

    localparam logic [20:0] C_SUPP_BASE = 21'h10000;

    // One classified unit: the bytes it causes, in order, and their count
    typedef struct packed {
        logic [C_MAX_BYTES-1:0][7:0] bytes;
        logic [C_CNT_W-1:0]          count;
        logic                        fin;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hdl/u2u_if.sv =====
// Interfaces: UTF-16 unit channel and UTF-8 byte channel.
`timescale 1ns / 1ps
interface u2u_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        final_unit;

    modport source (output valid, output code_unit, output final_unit, input ready);
    modport sink   (input valid, input code_unit, input final_unit, output ready);
endinterface

interface u2u_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       item_end;
    logic       text_end;

    modport source (output valid, output out_byte, output item_end, output text_end,
                    input ready);
    modport sink   (input valid, input out_byte, input item_end, input text_end,
                    output ready);
endinterface

// ===== hdl/u2u_front.sv =====
// Front end: accepts code units, pairs surrogates and builds byte jobs.
`timescale 1ns / 1ps
module u2u_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    u2u_unit_if.sink         i_unit,
    input  u2u_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output u2u_pkg::t_job    o_job
);
    import u2u_pkg::*;

    logic [9:0]  r_held_high, n_held_high;
    logic        r_held_valid, n_held_valid;

    logic        w_accept;
    logic [15:0] w_u;
    logic        w_is_high, w_is_low, w_pair;
    logic [20:0] w_cp;
    logic [15:0] w_flush_v;
    logic [2:0][7:0] w_ubytes;
    logic [1:0]  w_ucnt;

    assign i_unit.ready = !i_q_stat.full;
    assign w_accept     = i_unit.valid && i_unit.ready;
    assign w_u          = i_unit.code_unit;
    assign w_is_high    = (w_u[15:10] == C_HIGH_TAG);
    assign w_is_low     = (w_u[15:10] == C_LOW_TAG);
    assign w_pair       = r_held_valid && w_is_low;
    assign w_cp         = C_SUPP_BASE + {1'b0, r_held_high, w_u[9:0]};
    assign w_flush_v    = {C_HIGH_TAG, r_held_high};

    // Encoding of the unit itself, empty when it is held
    always_comb begin
        w_ubytes = '0;
        w_ucnt   = 2'd0;
        priority if (w_is_high && !i_unit.final_unit) begin
            w_ucnt = 2'd0;
        end else if (w_u[15:7] == 9'd0) begin
            w_ubytes[0] = w_u[7:0];
            w_ucnt      = 2'd1;
        end else if (w_u[15:11] == 5'd0) begin
            w_ubytes[0] = C_LEAD2 | {3'd0, w_u[10:6]};
            w_ubytes[1] = C_CONT  | {2'd0, w_u[5:0]};
            w_ucnt      = 2'd2;
        end else begin
            w_ubytes[0] = C_LEAD3 | {4'd0, w_u[15:12]};
            w_ubytes[1] = C_CONT  | {2'd0, w_u[11:6]};
            w_ubytes[2] = C_CONT  | {2'd0, w_u[5:0]};
            w_ucnt      = 2'd3;
        end
    end

    always_comb begin
        o_job     = '0;
        o_job.fin = i_unit.final_unit;
        priority if (w_pair) begin
            o_job.bytes[0] = C_LEAD4 | {5'd0, w_cp[20:18]};
            o_job.bytes[1] = C_CONT  | {2'd0, w_cp[17:12]};
            o_job.bytes[2] = C_CONT  | {2'd0, w_cp[11:6]};
            o_job.bytes[3] = C_CONT  | {2'd0, w_cp[5:0]};
            o_job.count    = C_CNT_W'(4);
        end else if (r_held_valid) begin
            // held high surrogate flushed in lenient form, then the new unit
            o_job.bytes[0] = C_LEAD3 | {4'd0, w_flush_v[15:12]};
            o_job.bytes[1] = C_CONT  | {2'd0, w_flush_v[11:6]};
            o_job.bytes[2] = C_CONT  | {2'd0, w_flush_v[5:0]};
            o_job.bytes[3] = w_ubytes[0];
            o_job.bytes[4] = w_ubytes[1];
            o_job.bytes[5] = w_ubytes[2];
            o_job.count    = C_CNT_W'(3) + C_CNT_W'(w_ucnt);
        end else begin
            o_job.bytes[0] = w_ubytes[0];
            o_job.bytes[1] = w_ubytes[1];
            o_job.bytes[2] = w_ubytes[2];
            o_job.count    = C_CNT_W'(w_ucnt);
        end
    end

    assign o_push = w_accept && (o_job.count != '0);

    always_comb begin
        n_held_high  = r_held_high;
        n_held_valid = r_held_valid;
        if (w_accept) begin
            if (!w_pair && w_is_high && !i_unit.final_unit) begin
                n_held_high  = w_u[9:0];
                n_held_valid = 1'b1;
            end else begin
                n_held_high  = '0;
                n_held_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_high  <= '0;
            r_held_valid <= 1'b0;
        end else begin
            r_held_high  <= n_held_high;
            r_held_valid <= n_held_valid;
        end
    end

endmodule

// ===== hdl/u2u_queue.sv =====
// Job queue between front and back end.
`timescale 1ns / 1ps
module u2u_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u2u_pkg::t_job    i_job,
    input  logic             i_pop,
    output u2u_pkg::t_job    o_head,
    output u2u_pkg::t_q_stat o_stat
);
    import u2u_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hdl/u2u_back.sv =====
// Back end: serializes the head job into registered UTF-8 bytes.
`timescale 1ns / 1ps
module u2u_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u2u_pkg::t_job    i_head,
    input  u2u_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    u2u_byte_if.source       o_byte
);
    import u2u_pkg::*;

    logic [C_IDX_W-1:0] r_idx, n_idx;
    logic               r_valid, n_valid;
    logic [7:0]         r_byte, n_byte;
    logic               r_item_end, n_item_end;
    logic               r_text_end, n_text_end;

    logic w_load, w_last;

    assign w_load = !r_valid || o_byte.ready;
    assign w_last = (C_CNT_W'(r_idx) == i_head.count - 1'b1);
    assign o_pop  = w_load && !i_q_stat.empty && w_last;

    always_comb begin
        n_idx      = r_idx;
        n_valid    = r_valid;
        n_byte     = r_byte;
        n_item_end = r_item_end;
        n_text_end = r_text_end;
        if (w_load) begin
            n_valid = !i_q_stat.empty;
            if (!i_q_stat.empty) begin
                n_byte     = i_head.bytes[r_idx];
                n_item_end = w_last;
                n_text_end = w_last && i_head.fin;
                n_idx      = w_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_item_end <= n_item_end;
        r_text_end <= n_text_end;
    end

    assign o_byte.valid    = r_valid;
    assign o_byte.out_byte = r_byte;
    assign o_byte.item_end = r_item_end;
    assign o_byte.text_end = r_text_end;

endmodule

// ===== hdl/utf16_to_utf8_transcoder.sv =====
// Top level: UTF-16 to UTF-8 transcoder, front end, job queue and byte serializer.
//
//  channel  dir  payload                          transfer when
//  i_unit   in   code_unit[15:0], final_unit      valid && ready
//  o_byte   out  out_byte[7:0], item_end, text_end valid && ready
//
//  A unit is taken every cycle while the job queue has room; the serializer
//  sends one byte a cycle while o_byte.ready is high, so the sustained unit
//  rate is set by the number of bytes the unit causes, up to six per job.
//  A non-final high surrogate causes no bytes of its own.
//  Synchronous active-low reset empties the queue and drops a held surrogate.
//  Output stalls back up into the queue; i_unit.ready falls only when it is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    u2u_unit_if.sink   i_unit,
    u2u_byte_if.source o_byte
);
    import u2u_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_job    w_job;
    t_job    w_head;
    t_q_stat w_stat;

    // Front end: surrogate pairing and byte building, one unit per cycle while the queue has room
    u2u_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_unit   (i_unit),
        .i_q_stat (w_stat),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    // Decouples unit intake from byte output
    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    // Back end: one byte per cycle into the output register while o_byte is ready
    u2u_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_stat),
        .o_pop    (w_pop),
        .o_byte   (o_byte)
    );

    // Queue bookkeeping and job sanity
    `U2U_ASSERT_NEVER(a_no_overflow, w_push && w_stat.full, "push into full queue")
    `U2U_ASSERT_NEVER(a_no_underflow, w_pop && w_stat.empty, "pop from empty queue")
    `U2U_ASSERT_IMPLY(a_job_nonempty, w_push, (w_job.count != '0) && (w_job.count <= C_CNT_W'(C_MAX_BYTES)), "bad job byte count")
    `U2U_ASSERT_IMPLY(a_text_end_last, o_byte.valid && o_byte.text_end, o_byte.item_end, "text_end without item_end")

endmodule
